// ----- src/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types, constants and helpers of the top-k score table.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int CAPACITY = 128;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int REG_W    = 8;
    localparam int CMPW     = (CW > REG_W) ? CW : REG_W;
    localparam int ID_W     = 32;
    localparam int SC_W     = 32;
    localparam int POS_W    = 7;
    localparam int IDX_W    = 2;

    typedef logic [AW-1:0]    addr_t;
    typedef logic [CW-1:0]    cnt_t;
    typedef logic [CMPW-1:0]  cmp_t;
    typedef logic [REG_W-1:0] cfg_reg_t;
    typedef logic [1:0]       tier_t;
    typedef logic [1:0]       kind_t;
    typedef logic [IDX_W-1:0] cfg_idx_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam kind_t KIND_NOTICE = 2'd0;
    localparam kind_t KIND_STATUS = 2'd1;
    localparam kind_t KIND_QUERY  = 2'd2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam tier_t TIER_NONE = 2'd0;
    localparam tier_t TIER_LOW  = 2'd1;
    localparam tier_t TIER_MID  = 2'd2;
    localparam tier_t TIER_TOP  = 2'd3;

    localparam cfg_idx_t REG_TIER_ONE = 2'd0;
    localparam cfg_idx_t REG_TIER_TWO = 2'd1;
    localparam cfg_idx_t REG_CAPACITY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [SC_W-1:0] score;
    } entry_t;

    typedef struct packed {
        cfg_reg_t tier_one_end;
        cfg_reg_t tier_two_end;
        cnt_t     cap;
        logic     cap_wr;
        cnt_t     cap_wr_value;
    } cfg_t;

    typedef struct packed {
        kind_t           kind;
        logic [ID_W-1:0] id;
        tier_t           tier;
        pos_t            pos;
        logic            accepted;
        logic            found;
        logic            promoted;
        logic            last;
    } res_t;

    // Clamp a raw capacity register value into 1..CAPACITY
    function automatic cnt_t eff_cap(cfg_reg_t v);
        cnt_t r;
        if (v == '0)
            r = cnt_t'(1);
        else if (cmp_t'(v) > cmp_t'(CAPACITY))
            r = cnt_t'(CAPACITY);
        else
            r = cnt_t'(v);
        return r;
    endfunction

    // Tier of a table position under the current bounds
    function automatic tier_t tier_of(cmp_t p, cfg_reg_t t1, cfg_reg_t t2, cnt_t cap);
        tier_t r;
        if (p < cmp_t'(t1))
            r = TIER_TOP;
        else if (p < cmp_t'(t2))
            r = TIER_MID;
        else if (p < cmp_t'(cap))
            r = TIER_LOW;
        else
            r = TIER_NONE;
        return r;
    endfunction

    // Low bits of a position for the result port
    function automatic pos_t pos_out(cnt_t p);
        logic [CW+POS_W-1:0] w;
        w = {{POS_W{1'b0}}, p};
        return w[POS_W-1:0];
    endfunction

endpackage

// ----- src/tks_ram.sv -----
// ----------------------------------------------------------------------------
// tks_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tks_ram (
    input  logic           clk,
    input  logic           wr_en,
    input  tks_pkg::addr_t wr_addr,
    input  tks_pkg::entry_t wr_data,
    input  logic           rd_en,
    input  tks_pkg::addr_t rd_addr,
    output tks_pkg::entry_t rd_data
);
    import tks_pkg::*;

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/tks_engine.sv -----
// ----------------------------------------------------------------------------
// tks_engine
// Sequencer of the score table: scans the entries through one compare unit,
// moves entries one per cycle, writes the new entry and issues the results.
// ----------------------------------------------------------------------------
module tks_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  tks_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            command,
    input  logic [31:0]     member_id,
    input  logic [31:0]     score,
    output logic            res_valid,
    input  logic            res_ready,
    output tks_pkg::res_t   res
);
    import tks_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_SCAN   = 12'b000000000010,
        S_DECIDE = 12'b000000000100,
        S_SHIFT  = 12'b000000001000,
        S_PUT    = 12'b000000010000,
        S_EVICT  = 12'b000000100000,
        S_OWN    = 12'b000001000000,
        S_B1_RD  = 12'b000010000000,
        S_B1     = 12'b000100000000,
        S_B2_RD  = 12'b001000000000,
        S_B2     = 12'b010000000000,
        S_STATUS = 12'b100000000000
    } state_t;

    // Control state
    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   cmp_vld_reg, cmp_vld_next;
    logic   wpend_reg, wpend_next;

    // Working registers
    logic            cmd_reg, cmd_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [SC_W-1:0] sc_reg, sc_next;
    cnt_t            rd_idx_reg, rd_idx_next;
    cnt_t            cmp_idx_reg, cmp_idx_next;
    logic            found_reg, found_next;
    cnt_t            old_pos_reg, old_pos_next;
    logic            has_new_reg, has_new_next;
    cnt_t            new_pos_reg, new_pos_next;
    logic [ID_W-1:0] last_id_reg, last_id_next;
    logic [SC_W-1:0] last_sc_reg, last_sc_next;
    addr_t           src_reg, src_next;
    cnt_t            remain_reg, remain_next;
    logic            dir_up_reg, dir_up_next;
    addr_t           waddr_reg, waddr_next;
    cnt_t            pos_reg, pos_next;
    cnt_t            newcnt_reg, newcnt_next;
    tier_t           new_tier_reg, new_tier_next;
    logic            evict_reg, evict_next;
    logic            chg_reg, chg_next;
    logic            b1_reg, b1_next;
    logic            b2_reg, b2_next;
    kind_t           st_kind_reg, st_kind_next;
    tier_t           st_tier_reg, st_tier_next;
    logic            st_acc_reg, st_acc_next;
    logic            st_prom_reg, st_prom_next;

    // Memory port signals
    logic   wr_en;
    addr_t  wr_addr;
    entry_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
    entry_t rd_data;

    // Decision helpers
    cnt_t  end_pos;
    cnt_t  fin_pos;
    tier_t old_tier;
    tier_t fin_tier;
    logic  reject;
    logic  full;

    tks_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmp_vld_next  = 1'b0;
        wpend_next    = 1'b0;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        sc_next       = sc_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        old_pos_next  = old_pos_reg;
        has_new_next  = has_new_reg;
        new_pos_next  = new_pos_reg;
        last_id_next  = last_id_reg;
        last_sc_next  = last_sc_reg;
        src_next      = src_reg;
        remain_next   = remain_reg;
        dir_up_next   = dir_up_reg;
        waddr_next    = waddr_reg;
        pos_next      = pos_reg;
        newcnt_next   = newcnt_reg;
        new_tier_next = new_tier_reg;
        evict_next    = evict_reg;
        chg_next      = chg_reg;
        b1_next       = b1_reg;
        b2_next       = b2_reg;
        st_kind_next  = st_kind_reg;
        st_tier_next  = st_tier_reg;
        st_acc_next   = st_acc_reg;
        st_prom_next  = st_prom_reg;

        wr_en   = 1'b0;
        wr_addr = waddr_reg;
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = rd_idx_reg[AW-1:0];

        res_valid = 1'b0;
        res       = '0;

        old_tier = found_reg ? tier_of(cmp_t'(old_pos_reg), cfg.tier_one_end,
                                       cfg.tier_two_end, cfg.cap) : TIER_NONE;
        full     = (count_reg >= cfg.cap) && (count_reg != '0);
        reject   = full && (sc_reg <= last_sc_reg);
        end_pos  = has_new_reg ? new_pos_reg : count_reg;
        fin_pos  = end_pos;
        fin_tier = TIER_NONE;

        case (state_reg)
            S_IDLE:
            begin
                // Clip the fill level when the capacity shrinks
                if (cfg.cap_wr && (count_reg > cfg.cap_wr_value))
                begin
                    count_next = cfg.cap_wr_value;
                end
                if (in_valid)
                begin
                    cmd_next     = command;
                    id_next      = member_id;
                    sc_next      = score;
                    rd_idx_next  = '0;
                    found_next   = 1'b0;
                    has_new_next = 1'b0;
                    old_pos_next = '0;
                    new_pos_next = '0;
                    state_next   = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Compare the entry read in the previous cycle
                if (cmp_vld_reg)
                begin
                    if (!found_reg && (rd_data.id == id_reg))
                    begin
                        found_next   = 1'b1;
                        old_pos_next = cmp_idx_reg;
                    end
                    if (!has_new_reg && (rd_data.score < sc_reg))
                    begin
                        has_new_next = 1'b1;
                        new_pos_next = cmp_idx_reg;
                    end
                    last_id_next = rd_data.id;
                    last_sc_next = rd_data.score;
                end
                // Issue the next read
                if (rd_idx_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    rd_idx_next  = rd_idx_reg + cnt_t'(1);
                    cmp_idx_next = rd_idx_reg;
                    cmp_vld_next = 1'b1;
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                st_tier_next = old_tier;
                st_acc_next  = 1'b0;
                st_prom_next = 1'b0;
                st_kind_next = (cmd_reg == CMD_QUERY) ? KIND_QUERY : KIND_STATUS;
                pos_next     = found_reg ? old_pos_reg : '0;
                if ((cmd_reg == CMD_QUERY) || reject)
                begin
                    state_next = S_STATUS;
                end
                else
                begin
                    evict_next = 1'b0;
                    if (found_reg && (old_pos_reg < end_pos))
                    begin
                        // Close the gap downward, land just above the first lower score
                        fin_pos     = end_pos - cnt_t'(1);
                        dir_up_next = 1'b0;
                        src_next    = addr_t'(old_pos_reg + cnt_t'(1));
                        remain_next = end_pos - cnt_t'(1) - old_pos_reg;
                        newcnt_next = count_reg;
                    end
                    else if (found_reg)
                    begin
                        // Open a gap upward over the old slot
                        fin_pos     = new_pos_reg;
                        dir_up_next = 1'b1;
                        src_next    = addr_t'(old_pos_reg - cnt_t'(1));
                        remain_next = old_pos_reg - new_pos_reg;
                        newcnt_next = count_reg;
                    end
                    else if (full)
                    begin
                        // Last entry drops out, the rest moves up
                        fin_pos     = end_pos;
                        dir_up_next = 1'b1;
                        src_next    = addr_t'(count_reg - cnt_t'(2));
                        remain_next = count_reg - cnt_t'(1) - end_pos;
                        newcnt_next = count_reg;
                        evict_next  = 1'b1;
                    end
                    else
                    begin
                        fin_pos     = end_pos;
                        dir_up_next = 1'b1;
                        src_next    = addr_t'(count_reg - cnt_t'(1));
                        remain_next = count_reg - end_pos;
                        newcnt_next = count_reg + cnt_t'(1);
                    end
                    fin_tier      = tier_of(cmp_t'(fin_pos), cfg.tier_one_end,
                                            cfg.tier_two_end, cfg.cap);
                    pos_next      = fin_pos;
                    new_tier_next = fin_tier;
                    chg_next      = (fin_tier != old_tier);
                    b1_next       = (fin_tier != old_tier) && (fin_tier == TIER_TOP) &&
                                    (cmp_t'(newcnt_next) > cmp_t'(cfg.tier_one_end));
                    b2_next       = (fin_tier != old_tier) &&
                                    (((fin_tier == TIER_TOP) && (old_tier < TIER_MID)) ||
                                     (fin_tier == TIER_MID)) &&
                                    (cmp_t'(newcnt_next) > cmp_t'(cfg.tier_two_end));
                    st_tier_next  = fin_tier;
                    st_acc_next   = 1'b1;
                    st_prom_next  = (fin_tier > old_tier);
                    state_next    = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Write the entry read in the previous cycle one slot over
                wr_en = wpend_reg;
                if (remain_reg != '0)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = src_reg;
                    wpend_next  = 1'b1;
                    waddr_next  = dir_up_reg ? (src_reg + addr_t'(1)) : (src_reg - addr_t'(1));
                    src_next    = dir_up_reg ? (src_reg - addr_t'(1)) : (src_reg + addr_t'(1));
                    remain_next = remain_reg - cnt_t'(1);
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg[AW-1:0];
                wr_data.id    = id_reg;
                wr_data.score = sc_reg;
                count_next    = newcnt_reg;
                if (evict_reg)
                    state_next = S_EVICT;
                else if (chg_reg)
                    state_next = S_OWN;
                else
                    state_next = S_STATUS;
            end

            S_EVICT:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_NOTICE;
                res.id    = last_id_reg;
                res.tier  = TIER_NONE;
                if (res_ready)
                    state_next = chg_reg ? S_OWN : S_STATUS;
            end

            S_OWN:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_NOTICE;
                res.id    = id_reg;
                res.tier  = new_tier_reg;
                if (res_ready)
                begin
                    if (b1_reg)
                        state_next = S_B1_RD;
                    else if (b2_reg)
                        state_next = S_B2_RD;
                    else
                        state_next = S_STATUS;
                end
            end

            S_B1_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_t'(cfg.tier_one_end);
                state_next = S_B1;
            end

            S_B1:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_NOTICE;
                res.id    = rd_data.id;
                res.tier  = tier_of(cmp_t'(cfg.tier_one_end), cfg.tier_one_end,
                                    cfg.tier_two_end, cfg.cap);
                if (res_ready)
                    state_next = b2_reg ? S_B2_RD : S_STATUS;
            end

            S_B2_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_t'(cfg.tier_two_end);
                state_next = S_B2;
            end

            S_B2:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_NOTICE;
                res.id    = rd_data.id;
                res.tier  = tier_of(cmp_t'(cfg.tier_two_end), cfg.tier_one_end,
                                    cfg.tier_two_end, cfg.cap);
                if (res_ready)
                    state_next = S_STATUS;
            end

            S_STATUS:
            begin
                res_valid    = 1'b1;
                res.kind     = st_kind_reg;
                res.id       = id_reg;
                res.tier     = st_tier_reg;
                res.pos      = pos_out(pos_reg);
                res.accepted = st_acc_reg;
                res.found    = found_reg;
                res.promoted = st_prom_reg;
                res.last     = 1'b1;
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            wpend_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            wpend_reg   <= wpend_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        sc_reg       <= sc_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        old_pos_reg  <= old_pos_next;
        has_new_reg  <= has_new_next;
        new_pos_reg  <= new_pos_next;
        last_id_reg  <= last_id_next;
        last_sc_reg  <= last_sc_next;
        src_reg      <= src_next;
        remain_reg   <= remain_next;
        dir_up_reg   <= dir_up_next;
        waddr_reg    <= waddr_next;
        pos_reg      <= pos_next;
        newcnt_reg   <= newcnt_next;
        new_tier_reg <= new_tier_next;
        evict_reg    <= evict_next;
        chg_reg      <= chg_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        st_kind_reg  <= st_kind_next;
        st_tier_reg  <= st_tier_next;
        st_acc_reg   <= st_acc_next;
        st_prom_reg  <= st_prom_next;
    end

`ifndef SYNTHESIS
    a_count_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cfg.cap)
        else $error("fill level above capacity");

    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SCAN))
        else $error("accepted request did not start a scan");

    a_put_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |=> (count_reg != '0))
        else $error("table empty after insert");

    a_shift_no_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (wpend_reg && (state_reg == S_SHIFT)) |-> $past(rd_en))
        else $error("shift write without a read behind it");
`endif

endmodule

// ----- src/top_k_score_table.sv -----
// ----------------------------------------------------------------------------
// top_k_score_table
// Sorted leaderboard of (member id, score) entries with three position tiers.
// ----------------------------------------------------------------------------
// One request at a time. An entry store with one write port and one read port
// is walked one entry per cycle, first to find the member and its insertion
// point, then to move the entries between the old and new slots. The table is
// empty after reset; no clearing pass is needed. Configuration writes are to
// be taken while idle: the user must issue them only then, as the block itself
// does not enforce this.
module top_k_score_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  command,
    input  logic [31:0]           member_id,
    input  logic [31:0]           score,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [31:0]           member_id_out,
    output logic [1:0]            tier,
    output logic [6:0]            position,
    output logic                  accepted,
    output logic                  found,
    output logic                  promoted,
    output logic                  last,
    input  logic                  cfg_wr_en,
    input  tks_pkg::cfg_idx_t     cfg_index,
    input  tks_pkg::cfg_reg_t     cfg_wr_data
);
    import tks_pkg::*;

    cfg_reg_t tier_one_reg;
    cfg_reg_t tier_two_reg;
    cfg_reg_t cap_reg;
    cfg_t     cfg;
    logic     res_valid;
    logic     res_ready;
    res_t     res;
    logic     out_valid_reg;
    res_t     out_res_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tier_one_reg <= cfg_reg_t'(3);
            tier_two_reg <= cfg_reg_t'(50);
            cap_reg      <= cfg_reg_t'(100);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TIER_ONE: tier_one_reg <= cfg_wr_data;
                REG_TIER_TWO: tier_two_reg <= cfg_wr_data;
                REG_CAPACITY: cap_reg      <= cfg_wr_data;
                default:      ;
            endcase
        end
    end

    // Bundle the settings for the engine
    always_comb
    begin
        cfg.tier_one_end = tier_one_reg;
        cfg.tier_two_end = tier_two_reg;
        cfg.cap          = eff_cap(cap_reg);
        cfg.cap_wr       = cfg_wr_en && (cfg_index == REG_CAPACITY);
        cfg.cap_wr_value = eff_cap(cfg_wr_data);
    end

    tks_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .member_id (member_id),
        .score     (score),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: hold a result until taken
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_res_reg.kind;
    assign member_id_out = out_res_reg.id;
    assign tier          = out_res_reg.tier;
    assign position      = out_res_reg.pos;
    assign accepted      = out_res_reg.accepted;
    assign found         = out_res_reg.found;
    assign promoted      = out_res_reg.promoted;
    assign last          = out_res_reg.last;

endmodule
